/* hdl/iorb_pkg.sv */
package iorb_pkg;

    localparam int SEQ_W      = 16;
    localparam int TAG_W      = 32;
    localparam int WINDOW_DEF = 16;

    typedef enum logic [1:0] {
        KIND_ACK = 2'd0,
        KIND_MSG = 2'd1,
        KIND_DUP = 2'd2,
        KIND_REJ = 2'd3
    } kind_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] payload_tag;
        logic             drop;
        logic             duplicate;
    } in_item_t;

    typedef struct packed {
        kind_t            kind;
        logic [SEQ_W-1:0] out_seq;
        logic [TAG_W-1:0] out_tag;
        logic             last;
    } out_item_t;

    // Classification of the packet offered on the input channel.
    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_INORDER,
        CLS_AHEAD,
        CLS_REJECT
    } cls_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK,
        ST_MSG,
        ST_DUP,
        ST_DACK,
        ST_DMSG,
        ST_REJ
    } state_t;

    typedef struct packed {
        logic  cap;
        logic  adv_inorder;
        logic  store;
        logic  load;
        kind_t kind;
        logic  use_drain;
        logic  last;
        logic  drain_adv;
    } cmd_t;

    typedef struct packed {
        cls_t cls;
        logic out_free;
        logic dup;
        logic succ_held;
        logic next_held;
    } sts_t;

endpackage

/* hdl/in_order_reorder_buffer.sv */
// Receiver-side reorder buffer for a stream of sequence-numbered packets.
// Input channel pkt/pkt_valid/pkt_stall: one transfer carries seq, payload_tag,
// drop and duplicate. Output channel res/res_valid/res_stall: one transfer
// carries kind (ack, message, duplicate, reject), out_seq, out_tag and last.
// The expected packet produces ack, message and an optional duplicate, then an
// ack and a message for every held successor, in order. Packets ahead within
// the window are stored silently, packets beyond it give one reject result,
// and dropped or older packets give nothing.
// Sequence: an accepted packet is classified in its transfer cycle; the output
// sequencer then holds one state per result (ack, message, duplicate, then an
// ack and a message for each drained entry, or a single reject), while stored
// and ignored packets need no sequencer state. The first result is loaded from
// the sequencer's ack or reject state into the output register once that
// register is free. The sequencer runs one result per cycle into a single
// output register while the output is not stalled, and the tag store is read
// through a registered port addressed by the next ring head.
// Reset clears the expected sequence number, the ring head and all held bits;
// the tag store is not cleared. A stall on the output holds the current result
// and freezes the sequencer; pkt_stall stays high until the last result of the
// packet is in the output register.
module in_order_reorder_buffer #(
    parameter int WINDOW = iorb_pkg::WINDOW_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pkt_valid,
    output logic                pkt_stall,
    input  iorb_pkg::in_item_t  pkt,
    output logic                res_valid,
    input  logic                res_stall,
    output iorb_pkg::out_item_t res
);
    import iorb_pkg::*;

    // Commands from the sequencer to the datapath and status back.
    cmd_t cmd;
    sts_t sts;

    // The controller walks through the results of one packet at a time.
    iorb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .sts       (sts),
        .cmd       (cmd),
        .pkt_stall (pkt_stall)
    );

    // The datapath holds the expected sequence number, the ring of held bits,
    // the tag store and the output register.
    iorb_dpath #(
        .WINDOW (WINDOW)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt       (pkt),
        .cmd       (cmd),
        .sts       (sts),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

`ifndef SYNTHESIS
    // A reject is always the single and therefore final result of its packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_REJ) |-> res.last)
        else $error("reject result without last");

    // An ack is always followed by its message, so it never closes a packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.kind == KIND_ACK && res.last))
        else $error("ack result marked last");

    // When new packets are taken, no held entry may sit at the ring head.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pkt_stall |-> !sts.succ_held)
        else $error("held entry left at head while idle");
`endif

endmodule

/* hdl/iorb_dpath.sv */
module iorb_dpath #(
    parameter int WINDOW = iorb_pkg::WINDOW_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pkt_valid,
    input  iorb_pkg::in_item_t  pkt,
    input  iorb_pkg::cmd_t      cmd,
    output iorb_pkg::sts_t      sts,
    output logic                res_valid,
    input  logic                res_stall,
    output iorb_pkg::out_item_t res
);
    import iorb_pkg::*;

    localparam int HW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [HW:0]    WIN_EXT  = (HW+1)'(WINDOW);
    localparam logic [HW-1:0]  HEAD_MAX = HW'(WINDOW - 1);
    localparam logic [SEQ_W-1:0] WIN_SEQ = SEQ_W'(WINDOW);

    logic [SEQ_W-1:0]  exp_seq_reg, exp_seq_next;
    logic [HW-1:0]     head_reg, head_next;
    logic [WINDOW-1:0] held_reg, held_next;
    logic              res_valid_reg, res_valid_next;
    out_item_t         res_reg, res_next;
    logic [SEQ_W-1:0]  seq_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic              dup_reg;
    logic [TAG_W-1:0]  rd_tag_reg;
    logic [TAG_W-1:0]  tag_mem [WINDOW];

    logic [SEQ_W-1:0]  distance;
    logic [HW-1:0]     head_inc;
    logic [HW:0]       slot_sum;
    logic [HW-1:0]     slot;
    cls_t              cls;

    assign distance = pkt.seq - exp_seq_reg;
    assign head_inc = (head_reg == HEAD_MAX) ? '0 : head_reg + 1'b1;
    assign slot_sum = {1'b0, head_reg} + distance[HW:0];
    assign slot     = (slot_sum >= WIN_EXT) ? HW'(slot_sum - WIN_EXT) : slot_sum[HW-1:0];

    always_comb
    begin
        if (!pkt_valid || pkt.drop)
        begin
            cls = CLS_NONE;
        end
        else if (distance == '0)
        begin
            cls = CLS_INORDER;
        end
        else if (distance < WIN_SEQ)
        begin
            cls = CLS_AHEAD;
        end
        else if (!distance[SEQ_W-1])
        begin
            cls = CLS_REJECT;
        end
        else
        begin
            cls = CLS_NONE;
        end
    end

    always_comb
    begin
        head_next    = head_reg;
        exp_seq_next = exp_seq_reg;
        held_next    = held_reg;
        if (cmd.store)
        begin
            held_next[slot] = 1'b1;
        end
        if (cmd.adv_inorder || cmd.drain_adv)
        begin
            held_next[head_reg] = 1'b0;
            head_next           = head_inc;
            exp_seq_next        = exp_seq_reg + 1'b1;
        end
    end

    always_comb
    begin
        res_next.kind    = cmd.kind;
        res_next.out_seq = cmd.use_drain ? exp_seq_reg : seq_reg;
        res_next.out_tag = cmd.use_drain ? rd_tag_reg : tag_reg;
        res_next.last    = cmd.last;
        if (cmd.load)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = res_valid_reg && res_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_seq_reg   <= '0;
            head_reg      <= '0;
            held_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            exp_seq_reg   <= exp_seq_next;
            head_reg      <= head_next;
            held_reg      <= held_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            seq_reg <= pkt.seq;
            tag_reg <= pkt.payload_tag;
            dup_reg <= pkt.duplicate;
        end
        if (cmd.load)
        begin
            res_reg <= res_next;
        end
    end

    // Tag store: written at the packet's ring slot, read at the next head.
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            tag_mem[slot] <= pkt.payload_tag;
        end
        rd_tag_reg <= tag_mem[head_next];
    end

    assign sts.cls       = cls;
    assign sts.out_free  = !res_valid_reg || !res_stall;
    assign sts.dup       = dup_reg;
    assign sts.succ_held = held_reg[head_reg];
    assign sts.next_held = held_reg[head_inc];

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* hdl/iorb_ctrl.sv */
module iorb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  iorb_pkg::sts_t  sts,
    output iorb_pkg::cmd_t  cmd,
    output logic            pkt_stall
);
    import iorb_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sts.cls == CLS_INORDER)
                begin
                    state_next = ST_ACK;
                end
                else if (sts.cls == CLS_REJECT)
                begin
                    state_next = ST_REJ;
                end
            end
            ST_ACK:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_MSG;
                end
            end
            ST_MSG:
            begin
                if (sts.out_free)
                begin
                    if (sts.dup)
                    begin
                        state_next = ST_DUP;
                    end
                    else
                    begin
                        state_next = sts.succ_held ? ST_DACK : ST_IDLE;
                    end
                end
            end
            ST_DUP:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.succ_held ? ST_DACK : ST_IDLE;
                end
            end
            ST_DACK:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_DMSG;
                end
            end
            ST_DMSG:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.next_held ? ST_DACK : ST_IDLE;
                end
            end
            ST_REJ:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.kind      = KIND_ACK;
        pkt_stall     = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                pkt_stall       = 1'b0;
                cmd.cap         = (sts.cls == CLS_INORDER) || (sts.cls == CLS_REJECT);
                cmd.adv_inorder = (sts.cls == CLS_INORDER);
                cmd.store       = (sts.cls == CLS_AHEAD);
            end
            ST_ACK:
            begin
                cmd.load = sts.out_free;
                cmd.kind = KIND_ACK;
            end
            ST_MSG:
            begin
                cmd.load = sts.out_free;
                cmd.kind = KIND_MSG;
                cmd.last = !sts.dup && !sts.succ_held;
            end
            ST_DUP:
            begin
                cmd.load = sts.out_free;
                cmd.kind = KIND_DUP;
                cmd.last = !sts.succ_held;
            end
            ST_DACK:
            begin
                cmd.load      = sts.out_free;
                cmd.kind      = KIND_ACK;
                cmd.use_drain = 1'b1;
            end
            ST_DMSG:
            begin
                cmd.load      = sts.out_free;
                cmd.kind      = KIND_MSG;
                cmd.use_drain = 1'b1;
                cmd.last      = !sts.next_held;
                cmd.drain_adv = sts.out_free;
            end
            ST_REJ:
            begin
                cmd.load = sts.out_free;
                cmd.kind = KIND_REJ;
                cmd.last = 1'b1;
            end
            default:
            begin
                pkt_stall = 1'b1;
            end
        endcase
    end

endmodule

/* tb/reorder_checker.sv */
`timescale 1ns / 100ps

module reorder_checker #(
    parameter int WINDOW = iorb_pkg::WINDOW_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pkt_valid,
    input  logic                pkt_stall,
    input  iorb_pkg::in_item_t  pkt,
    input  logic                res_valid,
    input  logic                res_stall,
    input  iorb_pkg::out_item_t res,
    output int                  failures,
    output int                  pending,
    output int                  results_seen,
    output int                  longest_train
);

    import iorb_pkg::*;

    localparam int MAX_REPORTS = 10;

    logic [SEQ_W-1:0]  next_seq;
    logic [WINDOW-1:0] held;
    logic [TAG_W-1:0]  held_tag [WINDOW];
    int                ring_head;
    int                error_count;
    int                seen_count;
    int                longest;

    // Results of one packet gather in train so that the final one can be
    // marked before they join the queue of results still due.
    out_item_t         train[$];
    out_item_t         due_q[$];

    task automatic add_result(input kind_t k, input logic [SEQ_W-1:0] s,
                              input logic [TAG_W-1:0] t);
        out_item_t r;
        r.kind    = k;
        r.out_seq = s;
        r.out_tag = t;
        r.last    = 1'b0;
        train.push_back(r);
    endtask

    task automatic predict_packet(input in_item_t p);
        logic [SEQ_W-1:0] distance;
        int               slot;
        int               i;
        out_item_t        r;
        train.delete();
        distance = p.seq - next_seq;
        if (!p.drop) begin
            if (distance == '0) begin
                add_result(KIND_ACK, p.seq, p.payload_tag);
                add_result(KIND_MSG, p.seq, p.payload_tag);
                if (p.duplicate) begin
                    add_result(KIND_DUP, p.seq, p.payload_tag);
                end
                held[ring_head] = 1'b0;
                next_seq        = next_seq + 1'b1;
                ring_head       = (ring_head + 1) % WINDOW;
                // Release every held successor until the next gap.
                while (held[ring_head]) begin
                    add_result(KIND_ACK, next_seq, held_tag[ring_head]);
                    add_result(KIND_MSG, next_seq, held_tag[ring_head]);
                    held[ring_head] = 1'b0;
                    next_seq        = next_seq + 1'b1;
                    ring_head       = (ring_head + 1) % WINDOW;
                end
            end else if (distance < WINDOW) begin
                slot           = (ring_head + distance) % WINDOW;
                held_tag[slot] = p.payload_tag;
                held[slot]     = 1'b1;
            end else if (distance[SEQ_W-1] == 1'b0) begin
                add_result(KIND_REJ, p.seq, p.payload_tag);
            end
        end
        for (i = 0; i < train.size(); i++) begin
            r      = train[i];
            r.last = (i == train.size() - 1);
            due_q.push_back(r);
        end
        if (train.size() > longest) begin
            longest = train.size();
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        out_item_t want;
        if (!rst_n) begin
            next_seq      = '0;
            held          = '0;
            ring_head     = 0;
            error_count   = 0;
            seen_count    = 0;
            longest       = 0;
            due_q.delete();
            failures      <= 0;
            pending       <= 0;
            results_seen  <= 0;
            longest_train <= 0;
        end else begin
            if (pkt_valid && !pkt_stall) begin
                predict_packet(pkt);
            end
            if (res_valid && !res_stall) begin
                seen_count++;
                if (due_q.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected result kind %0d seq %h tag %h last %b",
                                 $realtime, res.kind, res.out_seq, res.out_tag, res.last);
                    end
                end else begin
                    want = due_q.pop_front();
                    if (res.kind !== want.kind || res.out_seq !== want.out_seq ||
                        res.out_tag !== want.out_tag || res.last !== want.last) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch, expected kind %0d seq %h tag %h last %b",
                                     $realtime, want.kind, want.out_seq, want.out_tag,
                                     want.last);
                            $display("%0t:           got kind %0d seq %h tag %h last %b",
                                     $realtime, res.kind, res.out_seq, res.out_tag,
                                     res.last);
                        end
                    end
                end
            end
            failures      <= error_count;
            pending       <= due_q.size();
            results_seen  <= seen_count;
            longest_train <= longest;
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    import iorb_pkg::*;

    localparam int WINDOW        = WINDOW_DEF;
    // The longest quiet stretch in a correct run is a sender gap plus stalled or
    // busy cycles, so a run of IDLE_LIMIT idle cycles means a hang.
    localparam int IDLE_LIMIT    = 1000;
    localparam int RANDOM_ITEMS  = 100;
    // Stored and ignored packets give no result to wait for; this margin
    // lets any stray result show up before the verdict.
    localparam int SETTLE_CYCLES = 16;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_RARE
    } stall_mode_t;

    typedef enum int {
        NOISE_DROP,
        NOISE_OLD,
        NOISE_BEYOND,
        NOISE_REPEAT
    } noise_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      pkt_valid = 1'b0;
    logic      pkt_stall;
    in_item_t  pkt       = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    out_item_t res;

    int failures;
    int pending;
    int results_seen;
    int longest_train;

    int packets_sent = 0;
    int burst_left   = 1;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    in_order_reorder_buffer #(
        .WINDOW(WINDOW)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pkt_valid(pkt_valid),
        .pkt_stall(pkt_stall),
        .pkt      (pkt),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res)
    );

    reorder_checker #(
        .WINDOW(WINDOW)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .pkt_valid    (pkt_valid),
        .pkt_stall    (pkt_stall),
        .pkt          (pkt),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .res          (res),
        .failures     (failures),
        .pending      (pending),
        .results_seen (results_seen),
        .longest_train(longest_train)
    );

    // Offer one packet and hold it until the block takes the transfer. The
    // sender works in bursts: when a burst runs out, valid drops for a random
    // gap, and about one burst in four follows the previous one with no gap.
    task automatic send_pkt(input logic [SEQ_W-1:0] s, input logic [TAG_W-1:0] t,
                            input logic drop_f, input logic dup_f);
        in_item_t p;
        int       gap;
        p.seq         = s;
        p.payload_tag = t;
        p.drop        = drop_f;
        p.duplicate   = dup_f;
        pkt       <= p;
        pkt_valid <= 1'b1;
        @(posedge clk);
        while (pkt_stall) begin
            @(posedge clk);
        end
        packets_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                pkt_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // The receiver switches at random among stall patterns of its own: never
    // stalling, a coin toss, a heavy regular pattern that mostly stalls, and rarely.
    // The pattern ignores the sender, so stalls land on every phase of a
    // drain, including the first and the last result of a packet.
    stall_mode_t stall_mode  = STALL_NONE;
    int          stall_phase = 0;
    int          stall_tick  = 0;

    always @(posedge clk) begin
        if (stall_phase == 0) begin
            stall_mode  <= stall_mode_t'($urandom_range(0, 3));
            stall_phase <= $urandom_range(20, 80);
        end else begin
            stall_phase <= stall_phase - 1;
        end
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            STALL_NONE:  res_stall <= 1'b0;
            STALL_COIN:  res_stall <= 1'($urandom_range(0, 1));
            STALL_HEAVY: res_stall <= (stall_tick % 4) != 0;
            default:     res_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // The watchdog ends the run once the idle stretch in which neither channel
    // has moved a transfer reaches IDLE_LIMIT.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((pkt_valid && !pkt_stall) || (res_valid && !res_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("watchdog: no transfer for %0d cycles, %0d results still due",
                 IDLE_LIMIT, pending);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [SEQ_W-1:0] base_seq;
        int               directed_count;
        int               counted;
        int               k;
        int               i;
        int               j;
        int               tmp;
        int               order [WINDOW];
        noise_t           noise;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The block expects sequence 0 after reset.
        // A dropped packet gives nothing, even when it is the expected one.
        send_pkt(16'h0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
        // The expected packet with the duplicate flag, then one without it.
        send_pkt(16'h0000, 32'h0000_0000, 1'b0, 1'b1);
        send_pkt(16'h0001, 32'hFFFF_FFFF, 1'b0, 1'b0);
        // Sequence 0xFFFF lies just behind the expected 2 once the distance
        // wraps, so it is ignored.
        send_pkt(16'hFFFF, $urandom, 1'b0, 1'b1);
        // The first and the last distance beyond the window are rejected, and
        // the distance half way round counts as older and is ignored.
        send_pkt(SEQ_W'(2 + WINDOW), $urandom, 1'b0, 1'b0);
        send_pkt(16'd2 + 16'd32767, $urandom, 1'b0, 1'b1);
        send_pkt(16'd2 + 16'd32768, $urandom, 1'b0, 1'b0);
        // Fill the whole window ahead of the gap at 2, the far edge first,
        // and overwrite one held tag with a repeat.
        send_pkt(SEQ_W'(1 + WINDOW), $urandom, 1'b0, 1'b0);
        for (i = 3; i < WINDOW + 1; i++) begin
            send_pkt(i[SEQ_W-1:0], $urandom, 1'b0, 1'($urandom_range(0, 1)));
        end
        send_pkt(16'd5, $urandom, 1'b0, 1'b1);
        // Closing the gap with a duplicate gives the longest possible train:
        // three results for the packet and two for each of the held ones.
        send_pkt(16'd2, $urandom, 1'b0, 1'b1);
        directed_count = packets_sent;
        base_seq       = SEQ_W'(2 + WINDOW);

        // Random part. Each round sends every sequence of a short block once,
        // in shuffled order, so the expected number always moves on by the
        // block size. Noise is mixed in: drops, older packets, packets beyond
        // the window and repeats inside the block.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            k = ($urandom_range(0, 7) == 0) ? $urandom_range(9, WINDOW)
                                            : $urandom_range(1, 8);
            for (i = 0; i < k; i++) begin
                order[i] = i;
            end
            for (i = k - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (i = 0; i < k; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    noise = noise_t'($urandom_range(0, 3));
                    case (noise)
                        NOISE_DROP: begin
                            send_pkt(SEQ_W'($urandom), $urandom, 1'b1,
                                     1'($urandom_range(0, 1)));
                        end
                        NOISE_OLD: begin
                            send_pkt(SEQ_W'(base_seq - $urandom_range(1, 32768)), $urandom,
                                     1'b0, 1'($urandom_range(0, 1)));
                        end
                        NOISE_BEYOND: begin
                            send_pkt(SEQ_W'(base_seq + k + WINDOW + $urandom_range(0, 30000)),
                                     $urandom, 1'b0, 1'($urandom_range(0, 1)));
                            counted++;
                        end
                        default: begin
                            send_pkt(SEQ_W'(base_seq + $urandom_range(0, k - 1)), $urandom,
                                     1'b0, 1'($urandom_range(0, 1)));
                            counted++;
                        end
                    endcase
                end
                send_pkt(SEQ_W'(base_seq + order[i]), $urandom, 1'b0,
                         1'($urandom_range(0, 1)));
                counted++;
            end
            base_seq = SEQ_W'(base_seq + k);
        end
        pkt_valid <= 1'b0;

        // Every accepted packet has its results queued by now, so wait for
        // the queue to empty and then give stray results a chance to appear.
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d packets (%0d directed) with drops, older, held and rejected ones;",
                 packets_sent, directed_count);
        $display("checked %0d results under random stalls, longest train %0d results.",
                 results_seen, longest_train);
        if (failures == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/iorb_pkg.sv
hdl/iorb_dpath.sv
hdl/iorb_ctrl.sv
hdl/in_order_reorder_buffer.sv
tb/reorder_checker.sv
tb/tb_top.sv
